// ===== rtl/core/pbrs_pkg.sv =====
package pbrs_pkg;

  // store geometry and search reach
  localparam int MAX_WIDTH     = 512;
  localparam int MAX_HEIGHT    = 512;
  localparam int SEARCH_RADIUS = 10;

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int POS_W   = 9;
  localparam int COLOR_W = 8;
  localparam int RGB_W   = 3 * COLOR_W;
  localparam int DIM_W   = 10;
  localparam int RAD_W   = $clog2(SEARCH_RADIUS + 1);
  localparam int OFS_W   = $clog2(2 * SEARCH_RADIUS + 1);

  localparam logic [RGB_W-1:0] WHITE = '1;

  // input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    SIDE_TOP,
    SIDE_BOTTOM,
    SIDE_LEFT,
    SIDE_RIGHT
  } side_t;

  typedef struct packed {
    logic wr;          // store the pixel of the input transfer
    logic load;        // latch the query cursor
    logic init;        // set up radius and scan counters
    logic issue;       // read the current scan pixel and step
    logic emit;        // load the output register
    logic emit_found;
  } pbrs_cmd_t;

  typedef struct packed {
    logic outside;     // cursor outside the window
    logic issue_done;  // last scan pixel already read
    logic hit;         // returned pixel is not white
    logic miss_end;    // last pixel returned and it was white
  } pbrs_stat_t;

  function automatic logic [DIM_W-1:0] umin(input logic [DIM_W-1:0] a,
                                            input logic [DIM_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/pbrs_regs.sv =====
module pbrs_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbrs_pkg::PADDR_W-1:0]  paddr,
  input  logic [pbrs_pkg::PDATA_W-1:0]  pwdata,
  output logic [pbrs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [pbrs_pkg::DIM_W-1:0]    image_width,
  output logic [pbrs_pkg::DIM_W-1:0]    image_height
);

  logic [pbrs_pkg::DIM_W-1:0] width_r;
  logic [pbrs_pkg::DIM_W-1:0] height_r;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // registers are word aligned, so only the index bit selects
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= pbrs_pkg::DIM_W'(pbrs_pkg::MAX_WIDTH);
      height_r <= pbrs_pkg::DIM_W'(pbrs_pkg::MAX_HEIGHT);
    end else if (wr_en) begin
      case (paddr[2])
        pbrs_pkg::REG_WIDTH:  width_r  <= pwdata[pbrs_pkg::DIM_W-1:0];
        pbrs_pkg::REG_HEIGHT: height_r <= pwdata[pbrs_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pbrs_pkg::REG_WIDTH:  prdata = pbrs_pkg::PDATA_W'(width_r);
      pbrs_pkg::REG_HEIGHT: prdata = pbrs_pkg::PDATA_W'(height_r);
      default:              prdata = '0;
    endcase
  end

  assign image_width  = width_r;
  assign image_height = height_r;

endmodule

// ===== rtl/core/pbrs_ctrl.sv =====
module pbrs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  pbrs_pkg::pbrs_stat_t stat,
  output pbrs_pkg::pbrs_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   found_r, found_nxt;
  logic   out_valid_r;
  logic   accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cmd            = '0;
    cmd.wr         = accept && (in_command == pbrs_pkg::CMD_WRITE);
    cmd.load       = accept && (in_command == pbrs_pkg::CMD_QUERY);
    cmd.init       = (state_r == ST_CALC);
    // stop reading once a hit shows so its data stays in the read register
    cmd.issue      = (state_r == ST_SCAN) && !stat.issue_done && !stat.hit;
    cmd.emit       = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
    cmd.emit_found = found_r;
  end

  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (stat.outside) begin
          found_nxt = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.hit) begin
          found_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end else if (stat.miss_end) begin
          found_nxt = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd.emit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/pbrs_dpath.sv =====
module pbrs_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pbrs_pkg::POS_W-1:0]    in_pos_x,
  input  logic [pbrs_pkg::POS_W-1:0]    in_pos_y,
  input  logic [pbrs_pkg::COLOR_W-1:0]  in_red_in,
  input  logic [pbrs_pkg::COLOR_W-1:0]  in_green_in,
  input  logic [pbrs_pkg::COLOR_W-1:0]  in_blue_in,
  input  logic [pbrs_pkg::DIM_W-1:0]    image_width,
  input  logic [pbrs_pkg::DIM_W-1:0]    image_height,
  input  pbrs_pkg::pbrs_cmd_t           cmd,
  output pbrs_pkg::pbrs_stat_t          stat,
  output logic                          out_found,
  output logic [pbrs_pkg::COLOR_W-1:0]  out_red_out,
  output logic [pbrs_pkg::COLOR_W-1:0]  out_green_out,
  output logic [pbrs_pkg::COLOR_W-1:0]  out_blue_out
);

  logic [pbrs_pkg::RGB_W-1:0] mem [pbrs_pkg::DEPTH];

  logic [pbrs_pkg::POS_W-1:0]  x_r, y_r;
  logic [pbrs_pkg::RAD_W-1:0]  rad_r;
  logic [pbrs_pkg::RAD_W-1:0]  d_r;
  logic [pbrs_pkg::OFS_W-1:0]  k_r;
  pbrs_pkg::side_t             side_r;
  logic                        issue_done_r;
  logic                        rd_vld_r;
  logic                        rd_last_r;
  logic [pbrs_pkg::RGB_W-1:0]  rd_data_r;
  logic                        found_r;
  logic [pbrs_pkg::RGB_W-1:0]  rgb_r;

  logic [pbrs_pkg::DIM_W-1:0]  w_eff, h_eff, xe, ye, x_hi, y_hi, near;
  logic                        outside;
  logic [pbrs_pkg::RAD_W-1:0]  rad;
  logic [pbrs_pkg::POS_W-1:0]  xm, ym, col, row;
  logic [pbrs_pkg::OFS_W-1:0]  span;
  logic                        k_end, last;
  logic [pbrs_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic                        wr_in_store;

  // radius: distance to nearest border, capped
  always_comb begin
    w_eff = pbrs_pkg::umin(image_width, pbrs_pkg::DIM_W'(pbrs_pkg::MAX_WIDTH));
    h_eff = pbrs_pkg::umin(image_height, pbrs_pkg::DIM_W'(pbrs_pkg::MAX_HEIGHT));
    xe    = pbrs_pkg::DIM_W'(x_r);
    ye    = pbrs_pkg::DIM_W'(y_r);
    outside = (xe >= w_eff) || (ye >= h_eff);
    x_hi  = w_eff - pbrs_pkg::DIM_W'(1) - xe;
    y_hi  = h_eff - pbrs_pkg::DIM_W'(1) - ye;
    near  = pbrs_pkg::umin(pbrs_pkg::umin(xe, x_hi), pbrs_pkg::umin(ye, y_hi));
    if (near > pbrs_pkg::DIM_W'(pbrs_pkg::SEARCH_RADIUS)) begin
      rad = pbrs_pkg::RAD_W'(pbrs_pkg::SEARCH_RADIUS);
    end else begin
      rad = near[pbrs_pkg::RAD_W-1:0];
    end
  end

  // scan address: the center is ring 0 seen as a one-pixel right column
  always_comb begin
    xm = x_r - pbrs_pkg::POS_W'(d_r);
    ym = y_r - pbrs_pkg::POS_W'(d_r);
    case (side_r)
      pbrs_pkg::SIDE_TOP: begin
        col = xm + pbrs_pkg::POS_W'(k_r);
        row = ym;
      end
      pbrs_pkg::SIDE_BOTTOM: begin
        col = xm + pbrs_pkg::POS_W'(k_r);
        row = y_r + pbrs_pkg::POS_W'(d_r);
      end
      pbrs_pkg::SIDE_LEFT: begin
        col = xm;
        row = ym + pbrs_pkg::POS_W'(k_r);
      end
      pbrs_pkg::SIDE_RIGHT: begin
        col = x_r + pbrs_pkg::POS_W'(d_r);
        row = ym + pbrs_pkg::POS_W'(k_r);
      end
      default: begin
        col = x_r;
        row = y_r;
      end
    endcase
    span  = pbrs_pkg::OFS_W'({d_r, 1'b0});
    k_end = (k_r == span);
    last  = k_end && (side_r == pbrs_pkg::SIDE_RIGHT) && (d_r == rad_r);
    rd_addr = pbrs_pkg::ADDR_W'(row) * pbrs_pkg::ADDR_W'(pbrs_pkg::MAX_WIDTH)
            + pbrs_pkg::ADDR_W'(col);
    wr_addr = pbrs_pkg::ADDR_W'(in_pos_y) * pbrs_pkg::ADDR_W'(pbrs_pkg::MAX_WIDTH)
            + pbrs_pkg::ADDR_W'(in_pos_x);
    wr_in_store = ((pbrs_pkg::POS_W + 1)'(in_pos_x) <
                   (pbrs_pkg::POS_W + 1)'(pbrs_pkg::MAX_WIDTH)) &&
                  ((pbrs_pkg::POS_W + 1)'(in_pos_y) <
                   (pbrs_pkg::POS_W + 1)'(pbrs_pkg::MAX_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_in_store) begin
      mem[wr_addr] <= {in_red_in, in_green_in, in_blue_in};
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= in_pos_x;
      y_r <= in_pos_y;
    end
    if (cmd.init) begin
      rad_r  <= rad;
      d_r    <= '0;
      k_r    <= '0;
      side_r <= pbrs_pkg::SIDE_RIGHT;
    end else if (cmd.issue) begin
      if (k_end) begin
        k_r <= '0;
        case (side_r)
          pbrs_pkg::SIDE_TOP:    side_r <= pbrs_pkg::SIDE_BOTTOM;
          pbrs_pkg::SIDE_BOTTOM: side_r <= pbrs_pkg::SIDE_LEFT;
          pbrs_pkg::SIDE_LEFT:   side_r <= pbrs_pkg::SIDE_RIGHT;
          pbrs_pkg::SIDE_RIGHT: begin
            side_r <= pbrs_pkg::SIDE_TOP;
            d_r    <= d_r + pbrs_pkg::RAD_W'(1);
          end
          default: side_r <= pbrs_pkg::SIDE_TOP;
        endcase
      end else begin
        k_r <= k_r + pbrs_pkg::OFS_W'(1);
      end
    end
    if (cmd.issue) begin
      rd_last_r <= last;
    end
    if (cmd.emit) begin
      found_r <= cmd.emit_found;
      rgb_r   <= cmd.emit_found ? rd_data_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_done_r <= 1'b0;
      rd_vld_r     <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.init) begin
        issue_done_r <= 1'b0;
      end else if (cmd.issue && last) begin
        issue_done_r <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.outside    = outside;
    stat.issue_done = issue_done_r;
    stat.hit        = rd_vld_r && (rd_data_r != pbrs_pkg::WHITE);
    stat.miss_end   = rd_vld_r && rd_last_r && (rd_data_r == pbrs_pkg::WHITE);
  end

  assign out_found     = found_r;
  assign out_red_out   = rgb_r[3*pbrs_pkg::COLOR_W-1:2*pbrs_pkg::COLOR_W];
  assign out_green_out = rgb_r[2*pbrs_pkg::COLOR_W-1:pbrs_pkg::COLOR_W];
  assign out_blue_out  = rgb_r[pbrs_pkg::COLOR_W-1:0];

endmodule

// ===== rtl/core/pick_buffer_ring_search.sv =====
// Channel  Direction  Transfer when          Carries
// in_*     input      in_valid & !in_stall   command, pos_x, pos_y, red/green/blue_in
// out_*    output     out_valid & !out_stall found, red/green/blue_out (one per query)
// APB      input      psel & penable & pwrite  image_width at 0x0, image_height at 0x4
//
// A query inside the window reads one pixel per cycle, center first then ring by ring, up to
// 481 pixels at radius 10, set by the single read port of the pixel memory; a query outside
// the window reads no pixel. in_stall stays high while a query runs and until its result is
// in the output register; a stalled result does not block the next input transfer. Reset
// (rst_n low, synchronous) clears control and sets the size registers to their maximum; the
// pixel memory must be written before it is read.
module pick_buffer_ring_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [pbrs_pkg::POS_W-1:0]    in_pos_x,
  input  logic [pbrs_pkg::POS_W-1:0]    in_pos_y,
  input  logic [pbrs_pkg::COLOR_W-1:0]  in_red_in,
  input  logic [pbrs_pkg::COLOR_W-1:0]  in_green_in,
  input  logic [pbrs_pkg::COLOR_W-1:0]  in_blue_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [pbrs_pkg::COLOR_W-1:0]  out_red_out,
  output logic [pbrs_pkg::COLOR_W-1:0]  out_green_out,
  output logic [pbrs_pkg::COLOR_W-1:0]  out_blue_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbrs_pkg::PADDR_W-1:0]  paddr,
  input  logic [pbrs_pkg::PDATA_W-1:0]  pwdata,
  output logic [pbrs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [pbrs_pkg::DIM_W-1:0] image_width;
  logic [pbrs_pkg::DIM_W-1:0] image_height;
  pbrs_pkg::pbrs_cmd_t        cmd;
  pbrs_pkg::pbrs_stat_t       stat;

  pbrs_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .image_width  (image_width),
    .image_height (image_height)
  );

  pbrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  pbrs_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .image_width   (image_width),
    .image_height  (image_height),
    .cmd           (cmd),
    .stat          (stat),
    .out_found     (out_found),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out)
  );

endmodule

// ===== rtl/core/pbrs_chk.sv =====
module pbrs_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_command,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_found,
  input logic [pbrs_pkg::COLOR_W-1:0]  out_red_out,
  input logic [pbrs_pkg::COLOR_W-1:0]  out_green_out,
  input logic [pbrs_pkg::COLOR_W-1:0]  out_blue_out
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a miss carries zero color
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |->
      out_red_out == '0 && out_green_out == '0 && out_blue_out == '0)
    else $error("miss with nonzero color");

  // a pixel write makes no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == pbrs_pkg::CMD_WRITE && !out_valid
      |=> !out_valid)
    else $error("result after pixel write");

  // a query holds off the input while it searches
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == pbrs_pkg::CMD_QUERY |=> in_stall)
    else $error("input open during query");

endmodule

bind pick_buffer_ring_search pbrs_chk u_pbrs_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_command    (in_command),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_found     (out_found),
  .out_red_out   (out_red_out),
  .out_green_out (out_green_out),
  .out_blue_out  (out_blue_out)
);
